[hdl/tdt_pkg.sv]
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared constants, result codes and lane control type of the tile
// deduplication table.
// ----------------------------------------------------------------------------
`default_nettype none

package tdt_pkg;

  localparam int MAX_TILES_DEF       = 240;
  localparam int TILE_BYTES_DEF      = 256;
  localparam int PIXELS_PER_WORD_DEF = 8;

  localparam int LANES    = 8;
  localparam int LANE_BW  = $clog2(LANES);
  localparam int WORD_W   = 64;
  localparam int NUM_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_MATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic clr;
    logic vld;
    logic first;
    logic last;
  } tdt_scan_t;

endpackage

`default_nettype wire

[hdl/tile_dedup_table.sv]
// ----------------------------------------------------------------------------
// tile_dedup_table
// Tile deduplication table: collects tiles word by word and reports the
// first stored tile that matches, stores a new unique tile, or flags full.
//
//   channel  handshake              payload
//   input    start / busy           in_pixel_word
//   result   out_valid (1 cycle)    out_tile_number, out_status
//   config   cfg_we                 cfg_wdata (tile_limit)
//
// A new word is accepted only while idle (busy low): the eight lanes scan one
// row of stored tiles per cycle through their bank read port, then the last
// row is compared and the verdict is settled. The result strobe comes in the
// first idle cycle after the last word of a tile; other words give none.
// Reset is synchronous; no clearing pass is needed. Results cannot be held.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_dedup_table #(
  parameter int MAX_TILES       = tdt_pkg::MAX_TILES_DEF,
  parameter int TILE_BYTES      = tdt_pkg::TILE_BYTES_DEF,
  parameter int PIXELS_PER_WORD = tdt_pkg::PIXELS_PER_WORD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [63:0]                 in_pixel_word,
  output logic                             out_valid,
  output logic [tdt_pkg::NUM_W-1:0]        out_tile_number,
  output logic [tdt_pkg::STATUS_W-1:0]     out_status,
  input  wire logic                        cfg_we,
  input  wire logic [7:0]                  cfg_wdata
);

  import tdt_pkg::*;

  localparam int WPT    = (TILE_BYTES + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
  localparam int WW     = $clog2(WPT);
  localparam int ROWS   = (MAX_TILES + LANES - 1) / LANES;
  localparam int RB     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NRW    = $clog2(ROWS + 1);
  localparam int CW     = $clog2(MAX_TILES + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  function automatic logic [63:0] keep_mask(input logic [WW-1:0] k);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ((b < PIXELS_PER_WORD) && ((int'(k) * PIXELS_PER_WORD + b) < TILE_BYTES)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  logic              state_r, state_nxt;
  logic [7:0]        limit_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WW-1:0]     wcnt_r, wcnt_nxt;
  logic [WW-1:0]     k_r;
  logic [63:0]       word_r;
  logic              first_r;
  logic              last_r;
  logic [NRW-1:0]    rd_row_r, rd_row_nxt;
  logic              cmp_vld_r;
  logic [RB-1:0]     cmp_row_r;
  logic              out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0]  out_num_r, out_num_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  logic              accept;
  logic              issue_en;
  logic              done;
  logic              wr_en;
  logic [15:0]       cnt_ext;
  logic [15:0]       nrows_ext;
  logic [NRW-1:0]    nrows;
  logic [LANE_BW-1:0] wr_lane;
  logic [RB-1:0]     wr_row;
  logic [63:0]       masked_word;
  logic [7:0]        cnt8;
  logic [7:0]        lim;
  tdt_scan_t         scan;
  logic [LANES-1:0]  hits;
  logic              found;
  logic [NUM_W-1:0]  found_idx;

  always_comb begin
    accept      = start && (state_r == S_IDLE);
    cnt_ext     = 16'(count_r);
    nrows_ext   = (cnt_ext + 16'(LANES - 1)) >> LANE_BW;
    nrows       = nrows_ext[NRW-1:0];
    wr_lane     = cnt_ext[LANE_BW-1:0];
    wr_row      = cnt_ext[LANE_BW +: RB];
    wr_en       = accept && (cnt_ext < 16'(MAX_TILES));
    masked_word = in_pixel_word & keep_mask(wcnt_r);
    issue_en    = (state_r == S_SCAN) && (rd_row_r < nrows);
    done        = (state_r == S_SCAN) && !issue_en && !cmp_vld_r;
    cnt8        = 8'(count_r);
    lim         = (limit_r < 8'(MAX_TILES)) ? limit_r : 8'(MAX_TILES);
    scan.clr    = accept;
    scan.vld    = cmp_vld_r;
    scan.first  = first_r;
    scan.last   = last_r;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wcnt_nxt      = wcnt_r;
    rd_row_nxt    = rd_row_r;
    out_valid_nxt = 1'b0;
    out_num_nxt   = out_num_r;
    out_st_nxt    = out_st_r;
    if (accept) begin
      state_nxt  = S_SCAN;
      rd_row_nxt = '0;
      wcnt_nxt   = (wcnt_r == WW'(WPT - 1)) ? '0 : wcnt_r + 1'b1;
    end
    if (issue_en) begin
      rd_row_nxt = rd_row_r + 1'b1;
    end
    if (done) begin
      state_nxt = S_IDLE;
      if (last_r) begin
        out_valid_nxt = 1'b1;
        if (found) begin
          out_num_nxt = found_idx;
          out_st_nxt  = ST_MATCHED;
        end else if (cnt8 < lim) begin
          out_num_nxt = cnt8;
          out_st_nxt  = ST_STORED;
          count_nxt   = count_r + 1'b1;
        end else begin
          out_num_nxt = '0;
          out_st_nxt  = ST_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= 8'd240;
      count_r     <= '0;
      wcnt_r      <= '0;
      rd_row_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wcnt_r      <= wcnt_nxt;
      rd_row_r    <= rd_row_nxt;
      cmp_vld_r   <= issue_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_num_r <= out_num_nxt;
    out_st_r  <= out_st_nxt;
    cmp_row_r <= rd_row_r[RB-1:0];
    if (accept) begin
      word_r  <= masked_word;
      k_r     <= wcnt_r;
      first_r <= (wcnt_r == '0);
      last_r  <= (wcnt_r == WW'(WPT - 1));
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tdt_lane #(
      .LANE_ID (l),
      .RB      (RB),
      .WW      (WW),
      .CW      (CW)
    ) u_lane (
      .clk      (clk),
      .wr_en    (wr_en && (wr_lane == LANE_BW'(l))),
      .wr_addr  ({wr_row, wcnt_r}),
      .wr_data  (masked_word),
      .rd_en    (issue_en),
      .rd_addr  ({rd_row_r[RB-1:0], k_r}),
      .scan     (scan),
      .cmp_row  (cmp_row_r),
      .cmp_word (word_r),
      .count    (count_r),
      .hit      (hits[l])
    );
  end

  tdt_merge #(
    .RB (RB)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan),
    .cmp_row   (cmp_row_r),
    .hits      (hits),
    .found     (found),
    .found_idx (found_idx)
  );

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_tile_number = out_num_r;
  assign out_status      = out_st_r;

endmodule

`default_nettype wire

[hdl/tdt_ram.sv]
// ----------------------------------------------------------------------------
// tdt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/tdt_lane.sv]
// ----------------------------------------------------------------------------
// tdt_lane
// One compare lane: owns the bank of stored tiles whose index modulo the lane
// count equals this lane, compares one stored word per cycle with the
// current word and keeps a running match bit per stored tile.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_lane #(
  parameter int LANE_ID = 0,
  parameter int RB      = 5,
  parameter int WW      = 5,
  parameter int CW      = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [RB+WW-1:0]         wr_addr,
  input  wire logic [63:0]              wr_data,
  input  wire logic                     rd_en,
  input  wire logic [RB+WW-1:0]         rd_addr,
  input  wire tdt_pkg::tdt_scan_t       scan,
  input  wire logic [RB-1:0]            cmp_row,
  input  wire logic [63:0]              cmp_word,
  input  wire logic [CW-1:0]            count,
  output logic                          hit
);

  import tdt_pkg::*;

  localparam int ROWS_P2 = 1 << RB;

  logic [WORD_W-1:0]  rd_data;
  logic [ROWS_P2-1:0] match_r;
  logic               eq;
  logic               tile_ok;
  logic               match_nxt;
  logic [15:0]        tile_idx;

  tdt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS_P2 << WW)
  ) u_bank (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    tile_idx  = 16'((int'(cmp_row) * LANES) + LANE_ID);
    tile_ok   = tile_idx < 16'(count);
    eq        = rd_data == cmp_word;
    match_nxt = eq && (scan.first || match_r[cmp_row]);
    hit       = scan.vld && tile_ok && match_nxt;
  end

  always_ff @(posedge clk) begin
    if (scan.vld) begin
      match_r[cmp_row] <= match_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/tdt_merge.sv]
// ----------------------------------------------------------------------------
// tdt_merge
// Merging stage: takes the lane hits of each compared row, in row order, and
// keeps the lowest matching tile index of the last word of a tile.
// ----------------------------------------------------------------------------
`default_nettype none

module tdt_merge #(
  parameter int RB = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tdt_pkg::tdt_scan_t       scan,
  input  wire logic [RB-1:0]            cmp_row,
  input  wire logic [tdt_pkg::LANES-1:0] hits,
  output logic                          found,
  output logic [tdt_pkg::NUM_W-1:0]     found_idx
);

  import tdt_pkg::*;

  logic               found_r;
  logic               found_nxt;
  logic [NUM_W-1:0]   idx_r;
  logic [NUM_W-1:0]   idx_nxt;
  logic [LANE_BW-1:0] first_lane;

  always_comb begin
    first_lane = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (hits[l]) begin
        first_lane = LANE_BW'(l);
      end
    end
  end

  always_comb begin
    found_nxt = found_r;
    idx_nxt   = idx_r;
    if (scan.clr) begin
      found_nxt = 1'b0;
      idx_nxt   = '0;
    end else if (scan.vld && scan.last && !found_r && (|hits)) begin
      found_nxt = 1'b1;
      idx_nxt   = NUM_W'((int'(cmp_row) * LANES) + int'(first_lane));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign found     = found_r;
  assign found_idx = idx_r;

endmodule

`default_nettype wire

[bench/tb_tile_dedup_table.sv]
// ----------------------------------------------------------------------------
// tb_tile_dedup_table
// Self-checking bench for the tile deduplication table. Pixel words are
// sent as whole tiles: repeats of stored tiles, near copies that differ in
// a single bit, and fresh random tiles. An in-bench lookup model predicts
// the tile number and status of every completed tile. Each result is
// compared with the oldest prediction. The tile limit is moved through
// zero, one, below the count, the reset value and 255, and the table is
// filled up to the limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tile_dedup_table;
  import tdt_pkg::*;

  localparam int MAX_TILES      = MAX_TILES_DEF;
  localparam int WORDS_PER_TILE =
    (TILE_BYTES_DEF + PIXELS_PER_WORD_DEF - 1) / PIXELS_PER_WORD_DEF;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_GAP        = 10;

  typedef logic [WORDS_PER_TILE-1:0][WORD_W-1:0] tile_t;

  typedef struct packed {
    logic [NUM_W-1:0]    tile_number;
    logic [STATUS_W-1:0] status;
  } lookup_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [63:0]         in_pixel_word;
  logic                out_valid;
  logic [NUM_W-1:0]    out_tile_number;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_we;
  logic [7:0]          cfg_wdata;

  tile_t   tile_rows [MAX_TILES];
  tile_t   rx_tile;
  tile_t   refused_tile;
  int      rx_count;
  int      stored_tiles;
  int      limit_q;
  lookup_t lookup_q [$];
  int      mismatches;

  tile_dedup_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pixel_word   (in_pixel_word),
    .out_valid       (out_valid),
    .out_tile_number (out_tile_number),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Lookup model

  function automatic logic [63:0] keep_pixels(input int idx, input logic [63:0] w);
    int first;
    int n;
    first = idx * PIXELS_PER_WORD_DEF;
    n = PIXELS_PER_WORD_DEF;
    if (first + n > TILE_BYTES_DEF) n = TILE_BYTES_DEF - first;
    if (n >= 8) return w;
    return w & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  task automatic absorb_word(input logic [63:0] w);
    lookup_t r;
    int      hit;
    int      cap;
    int      t;
    rx_tile[rx_count] = keep_pixels(rx_count, w);
    rx_count++;
    if (rx_count == WORDS_PER_TILE) begin
      rx_count = 0;
      hit = -1;
      for (t = 0; t < stored_tiles && hit < 0; t++) begin
        if (tile_rows[t] == rx_tile) hit = t;
      end
      cap = (limit_q > MAX_TILES) ? MAX_TILES : limit_q;
      if (hit >= 0) begin
        r.tile_number = NUM_W'(hit);
        r.status = ST_MATCHED;
      end else if (stored_tiles < cap) begin
        tile_rows[stored_tiles] = rx_tile;
        r.tile_number = NUM_W'(stored_tiles);
        r.status = ST_STORED;
        stored_tiles++;
      end else begin
        refused_tile = rx_tile;
        r.tile_number = '0;
        r.status = ST_FULL;
      end
      lookup_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_lookup();
    lookup_t exp_r;
    if (lookup_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result: tile_number %0d status %0d",
                                out_tile_number, out_status));
    end else begin
      exp_r = lookup_q.pop_front();
      if (out_tile_number !== exp_r.tile_number || out_status !== exp_r.status)
        report_mismatch($sformatf(
          "expected tile_number %0d status %0d, got tile_number %0d status %0d",
          exp_r.tile_number, exp_r.status, out_tile_number, out_status));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) absorb_word(in_pixel_word);
    if (rst_n && out_valid) check_lookup();
  end

  // Stimulus helpers

  task automatic send_word(input logic [63:0] w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_pixel_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_tile(input tile_t t, input int max_gap);
    int k;
    for (k = 0; k < WORDS_PER_TILE; k++)
      send_word(t[k], $urandom_range(0, max_gap));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_tile_limit(input int v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v[7:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_q = v & 8'hFF;
  endtask

  function automatic tile_t random_tile();
    tile_t t;
    int    k;
    for (k = 0; k < WORDS_PER_TILE; k++) t[k] = {$urandom, $urandom};
    return t;
  endfunction

  function automatic tile_t fill_tile(input logic [63:0] w);
    tile_t t;
    int    k;
    for (k = 0; k < WORDS_PER_TILE; k++) t[k] = w;
    return t;
  endfunction

  // Tests

  task automatic test_directed();
    tile_t t;
    send_tile(fill_tile('0), 0);
    send_tile(fill_tile('1), MAX_GAP);
    send_tile(fill_tile('0), 0);
    send_tile(fill_tile(64'h55AA_55AA_55AA_55AA), MAX_GAP);
    t = fill_tile('1);
    t[WORDS_PER_TILE-1][63] = 1'b0;
    send_tile(t, 0);
    t = fill_tile('1);
    t[0][0] = 1'b0;
    send_tile(t, MAX_GAP);
    send_tile(fill_tile('1), 0);
  endtask

  task automatic test_limit_edges();
    tile_t t;
    set_tile_limit(0);
    send_tile(random_tile(), MAX_GAP);
    send_tile(fill_tile('0), 0);
    set_tile_limit(1);
    send_tile(random_tile(), 0);
    send_tile(fill_tile('1), MAX_GAP);
    set_tile_limit(stored_tiles + 1);
    send_tile(random_tile(), 0);
    send_tile(random_tile(), 0);
    wait_idle();
    t = refused_tile;
    set_tile_limit(stored_tiles + 1);
    send_tile(t, MAX_GAP);
  endtask

  task automatic test_random_traffic();
    tile_t t;
    int    i;
    int    r;
    int    k;
    int    b;
    for (i = 0; i < 6; i++) begin
      if (i % 3 == 0) begin
        case ($urandom_range(0, 3))
          0: set_tile_limit($urandom_range(0, 255));
          1: set_tile_limit(stored_tiles);
          2: set_tile_limit(stored_tiles + $urandom_range(1, 10));
          default: set_tile_limit(255);
        endcase
      end
      if (i == 4) wait_idle();
      r = $urandom_range(0, 9);
      if (r < 4 && stored_tiles > 0) begin
        t = tile_rows[$urandom_range(0, stored_tiles - 1)];
      end else if (r < 6 && stored_tiles > 0) begin
        t = tile_rows[$urandom_range(0, stored_tiles - 1)];
        k = $urandom_range(0, WORDS_PER_TILE - 1);
        b = $urandom_range(0, 63);
        t[k][b] = ~t[k][b];
      end else if (r == 9) begin
        t = refused_tile;
      end else begin
        t = random_tile();
      end
      send_tile(t, $urandom_range(0, 1) ? MAX_GAP : 0);
    end
  endtask

  task automatic test_fill_table();
    int    i;
    tile_t t;
    set_tile_limit(stored_tiles + 2);
    for (i = 0; i < 3; i++) send_tile(random_tile(), 0);
    wait_idle();
    t = tile_rows[stored_tiles - 1];
    send_tile(t, MAX_GAP);
    send_tile(tile_rows[0], 0);
    set_tile_limit(255);
    send_tile(random_tile(), MAX_GAP);
    set_tile_limit(MAX_TILES);
    send_tile(t, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_word = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rx_tile = '0;
    refused_tile = '0;
    rx_count = 0;
    stored_tiles = 0;
    limit_q = MAX_TILES;
    mismatches = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_limit_edges();
    test_random_traffic();
    test_fill_table();

    wait_idle();
    if (mismatches == 0 && lookup_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
